// ===== sv/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional sequence list package
// Shared widths, operation codes and the control bundle for the chain of cells.
// ----------------------------------------------------------------------------
package psl_pkg;

  // Number of cells in the chain. Valid range is 2 to 31.
  localparam int CAPACITY = 16;

  // Width that holds an element count from zero up to CAPACITY.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Widths fixed by the item format.
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int OCNT_W   = 5;
  localparam int STATUS_W = 2;

  // Width for comparing a position with a count without overflow.
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_BACK  = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_LIST      = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // The operation that every cell of the chain performs.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  // Control broadcast to every cell.
  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] idx;    // target index of an insert or delete
    logic [CNT_W-1:0] count;  // elements held before the operation
  } cell_ctrl_t;

endpackage

// ===== sv/positional_sequence_list_top.sv =====
// ----------------------------------------------------------------------------
// Positional sequence list
// Bounded ordered list of signed 32-bit values held in a shifting chain of
// cells, with inserts and deletes at either end or at a position, and listing.
// ----------------------------------------------------------------------------
// An item is accepted at a rising edge where start is high and busy is low.
// Every edit (insert or delete, accepted or rejected) gives a single result. An
// accepted edit shifts the cells from its target index on by one place at the
// accepting edge; the result appears on the out_ ports, marked by out_valid, in
// the next cycle. Listing N elements keeps busy high while the chain rotates by
// one cell per cycle, the front cell being read out each time, so results come
// one per cycle, front to back; after N rotations the order is back where it
// started. Listing an empty list gives one result in the next cycle.
// Each result is shown for exactly one cycle and the receiver cannot stall it,
// so it must take every cycle in which out_valid is high. The last result an
// item causes carries out_last_of_run, and every result reports the element
// count after the operation and a status.
module positional_sequence_list_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [psl_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [psl_pkg::DATA_W-1:0]   in_value,
  input  logic [psl_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  output logic signed [psl_pkg::DATA_W-1:0]   out_element,
  output logic                                out_last_of_run,
  output logic [psl_pkg::OCNT_W-1:0]          out_element_count,
  output logic [psl_pkg::STATUS_W-1:0]        out_status
);

  // Control state.
  psl_pkg::state_t              state_r;
  psl_pkg::state_t              state_nxt;
  logic [psl_pkg::CNT_W-1:0]    count_r;
  logic [psl_pkg::CNT_W-1:0]    count_nxt;
  logic [psl_pkg::CNT_W-1:0]    list_idx_r;
  logic [psl_pkg::CNT_W-1:0]    list_idx_nxt;

  // Result register.
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [psl_pkg::DATA_W-1:0]   out_element_r;
  logic [psl_pkg::DATA_W-1:0]   out_element_nxt;
  logic                         out_last_r;
  logic                         out_last_nxt;
  logic [psl_pkg::OCNT_W-1:0]   out_count_r;
  logic [psl_pkg::OCNT_W-1:0]   out_count_nxt;
  psl_pkg::status_t             out_status_r;
  psl_pkg::status_t             out_status_nxt;

  // Chain of cells.
  psl_pkg::cell_ctrl_t          ctrl;
  logic [psl_pkg::DATA_W-1:0]   new_value;
  logic [psl_pkg::DATA_W-1:0]   cell_value [psl_pkg::CAPACITY];

  // Decode helpers.
  psl_pkg::mode_t               mode;
  logic                         accept;
  logic                         is_full;
  logic                         is_empty;
  logic                         list_last;
  logic [psl_pkg::CMP_W-1:0]    pos_ext;
  logic [psl_pkg::CMP_W-1:0]    cnt_ext;
  logic [psl_pkg::CMP_W-1:0]    cnt_nxt_ext;
  logic [psl_pkg::CNT_W-1:0]    pos_idx;

  assign mode      = psl_pkg::mode_t'(in_mode);
  assign busy      = (state_r == psl_pkg::S_LIST);
  assign accept    = start && !busy;
  assign is_full   = (count_r == psl_pkg::CNT_W'(psl_pkg::CAPACITY));
  assign is_empty  = (count_r == '0);
  assign list_last = ((list_idx_r + psl_pkg::CNT_W'(1)) == count_r);

  assign pos_ext     = psl_pkg::CMP_W'(in_position);
  assign cnt_ext     = psl_pkg::CMP_W'(count_r);
  assign cnt_nxt_ext = psl_pkg::CMP_W'(count_nxt);
  // Only used once the position is known to lie within 1..count+1.
  assign pos_idx     = psl_pkg::CNT_W'(pos_ext - psl_pkg::CMP_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psl_pkg::S_IDLE: begin
        if (accept && (mode == psl_pkg::MODE_LIST) && !is_empty) begin
          state_nxt = psl_pkg::S_LIST;
        end
      end
      psl_pkg::S_LIST: begin
        if (list_last) begin
          state_nxt = psl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = psl_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: cell control, count update and the next result.
  always_comb begin
    ctrl.op         = psl_pkg::CELL_HOLD;
    ctrl.idx        = '0;
    ctrl.count      = count_r;
    new_value       = in_value;
    count_nxt       = count_r;
    list_idx_nxt    = list_idx_r;
    out_valid_nxt   = 1'b0;
    out_element_nxt = '0;
    out_last_nxt    = 1'b1;
    out_status_nxt  = psl_pkg::ST_DONE;

    case (state_r)
      psl_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (mode)
            psl_pkg::MODE_INS_FRONT: begin
              if (is_full) begin
                out_status_nxt = psl_pkg::ST_FULL;
              end else begin
                ctrl.op  = psl_pkg::CELL_INS;
                ctrl.idx = '0;
              end
            end
            psl_pkg::MODE_INS_BACK: begin
              if (is_full) begin
                out_status_nxt = psl_pkg::ST_FULL;
              end else begin
                ctrl.op  = psl_pkg::CELL_INS;
                ctrl.idx = count_r;
              end
            end
            psl_pkg::MODE_INS_POS: begin
              // The position is checked before fullness.
              if ((pos_ext == '0) || (pos_ext > (cnt_ext + psl_pkg::CMP_W'(1)))) begin
                out_status_nxt = psl_pkg::ST_BADPOS;
              end else if (is_full) begin
                out_status_nxt = psl_pkg::ST_FULL;
              end else begin
                ctrl.op  = psl_pkg::CELL_INS;
                ctrl.idx = pos_idx;
              end
            end
            psl_pkg::MODE_DEL_FRONT: begin
              if (is_empty) begin
                out_status_nxt = psl_pkg::ST_EMPTY;
              end else begin
                ctrl.op  = psl_pkg::CELL_DEL;
                ctrl.idx = '0;
              end
            end
            psl_pkg::MODE_DEL_BACK: begin
              if (is_empty) begin
                out_status_nxt = psl_pkg::ST_EMPTY;
              end else begin
                ctrl.op  = psl_pkg::CELL_DEL;
                ctrl.idx = count_r - psl_pkg::CNT_W'(1);
              end
            end
            psl_pkg::MODE_DEL_POS: begin
              // An empty list is reported before a bad position.
              if (is_empty) begin
                out_status_nxt = psl_pkg::ST_EMPTY;
              end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                out_status_nxt = psl_pkg::ST_BADPOS;
              end else begin
                ctrl.op  = psl_pkg::CELL_DEL;
                ctrl.idx = pos_idx;
              end
            end
            psl_pkg::MODE_LIST: begin
              if (is_empty) begin
                out_status_nxt = psl_pkg::ST_EMPTY;
              end else begin
                // Results start in the listing state.
                out_valid_nxt = 1'b0;
                list_idx_nxt  = '0;
              end
            end
            default: begin
              // The unused mode only reports a done result.
              out_status_nxt = psl_pkg::ST_DONE;
            end
          endcase

          if (ctrl.op == psl_pkg::CELL_INS) begin
            count_nxt = count_r + psl_pkg::CNT_W'(1);
          end else if (ctrl.op == psl_pkg::CELL_DEL) begin
            count_nxt = count_r - psl_pkg::CNT_W'(1);
          end
        end
      end
      psl_pkg::S_LIST: begin
        // Read the front cell and rotate it round to the back.
        ctrl.op         = psl_pkg::CELL_ROT;
        new_value       = cell_value[0];
        out_valid_nxt   = 1'b1;
        out_element_nxt = cell_value[0];
        out_last_nxt    = list_last;
        list_idx_nxt    = list_idx_r + psl_pkg::CNT_W'(1);
      end
      default: begin
        ctrl.op = psl_pkg::CELL_HOLD;
      end
    endcase
  end

  assign out_count_nxt = cnt_nxt_ext[psl_pkg::OCNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psl_pkg::S_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_idx_r  <= list_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
    out_count_r   <= out_count_nxt;
    out_status_r  <= out_status_nxt;
  end

  // The chain itself: each cell sees its two neighbors.
  for (genvar g = 0; g < psl_pkg::CAPACITY; g++) begin : g_cell
    logic [psl_pkg::DATA_W-1:0] left_v;
    logic [psl_pkg::DATA_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_inner_l
      assign left_v = cell_value[g-1];
    end

    if (g == psl_pkg::CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner_r
      assign right_v = cell_value[g+1];
    end

    psl_cell u_cell (
      .clk         (clk),
      .my_idx      (psl_pkg::CNT_W'(g)),
      .ctrl        (ctrl),
      .new_value   (new_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[g])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_element       = out_element_r;
  assign out_last_of_run   = out_last_r;
  assign out_element_count = out_count_r;
  assign out_status        = out_status_r;

  // The count never goes past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= psl_pkg::CNT_W'(psl_pkg::CAPACITY))
    else $error("element count exceeds capacity");

  // Listing never changes the count.
  a_list_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psl_pkg::S_LIST) |=> (count_r == $past(count_r)))
    else $error("count changed while listing");

  // A full report only comes with a full list.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == psl_pkg::ST_FULL)) |->
      (count_r == psl_pkg::CNT_W'(psl_pkg::CAPACITY)))
    else $error("full status on a list that is not full");

  // The listing position stays below the count.
  a_list_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psl_pkg::S_LIST) |-> (list_idx_r < count_r))
    else $error("listing index out of range");

endmodule

// ===== sv/psl_cell.sv =====
// ----------------------------------------------------------------------------
// Positional sequence list cell
// One storage cell of the chain; takes its left or right neighbor, a new value
// or holds, as the broadcast control and its own place in the chain decide.
// ----------------------------------------------------------------------------
module psl_cell (
  input  logic                             clk,
  input  logic [psl_pkg::CNT_W-1:0]        my_idx,
  input  psl_pkg::cell_ctrl_t              ctrl,
  input  logic [psl_pkg::DATA_W-1:0]       new_value,
  input  logic [psl_pkg::DATA_W-1:0]       left_value,
  input  logic [psl_pkg::DATA_W-1:0]       right_value,
  output logic [psl_pkg::DATA_W-1:0]       value
);

  logic [psl_pkg::DATA_W-1:0] data_r;
  logic [psl_pkg::DATA_W-1:0] data_nxt;
  logic [psl_pkg::CNT_W-1:0]  my_idx_inc;

  assign my_idx_inc = my_idx + psl_pkg::CNT_W'(1);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      psl_pkg::CELL_INS: begin
        if (my_idx == ctrl.idx) begin
          data_nxt = new_value;
        end else if ((my_idx > ctrl.idx) && (my_idx <= ctrl.count)) begin
          data_nxt = left_value;
        end
      end
      psl_pkg::CELL_DEL: begin
        if ((my_idx >= ctrl.idx) && (my_idx_inc < ctrl.count)) begin
          data_nxt = right_value;
        end
      end
      psl_pkg::CELL_ROT: begin
        // The front element wraps to the last occupied cell.
        if (my_idx_inc < ctrl.count) begin
          data_nxt = right_value;
        end else if (my_idx_inc == ctrl.count) begin
          data_nxt = new_value;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign value = data_r;

endmodule
